// File: src/gn2d_pkg.sv
package gn2d_pkg;

   // default build-time sizes
   localparam int DEFAULT_MAX_GRID_SIDE = 64;
   localparam int DEFAULT_FRACTION_BITS = 8;

   // request and response field widths
   localparam int INDEX_W = 12;
   localparam int GRAD_W  = 16;
   localparam int POINT_W = 14;
   localparam int NOISE_W = 16;
   localparam int ENTRY_W = 2 * GRAD_W;

   // request tdata layout, lowest field first
   localparam int IDX_LSB    = 0;
   localparam int GX_LSB     = IDX_LSB + INDEX_W;
   localparam int GY_LSB     = GX_LSB + GRAD_W;
   localparam int PX_LSB     = GY_LSB + GRAD_W;
   localparam int PY_LSB     = PX_LSB + POINT_W;
   localparam int REQ_DATA_W = PY_LSB + POINT_W;

   // configuration registers
   localparam int SIZE_W            = 7;
   localparam int CSR_INDEX_W       = 1;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   // pipeline control handed to the interpolation datapath
   typedef struct packed {
      logic advance;
      logic sample;
   } pipe_ctrl_type;

endpackage

// File: src/gradient_noise_2d_sampler.sv
// channel   dir  ports                              carries
// req       in   req_tvalid/tready/tdata/tuser      tuser: operation; tdata: entry, gradient, point
// rsp       out  rsp_tvalid/tready/tdata            tdata: noise_value
// csr       in   csr_valid/ready/index/data         grid_width (0), grid_height (1)
//
// one request per cycle unless stalled, writes and samples alike; the four corner reads come from
// two copies of the gradient table, each with two read ports, so no request waits on the table
// a sample's result goes through stages s1 to s4 and the output register; writes give none
// a write lands at its accepting edge, so a sample in the very next cycle already reads it
// synchronous reset clears the pipeline and sets both sizes to 64; the table is not cleared
// a two-entry output buffer absorbs a stalled rsp side; req_tready drops only when both are full
module gradient_noise_2d_sampler #(
   parameter int MAX_GRID_SIDE = gn2d_pkg::DEFAULT_MAX_GRID_SIDE,
   parameter int FRACTION_BITS = gn2d_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // entry_index, gradient_x, gradient_y, point_x, point_y
   input  logic [gn2d_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // noise_value
   output logic [gn2d_pkg::NOISE_W-1:0]         rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gn2d_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gn2d_pkg::SIZE_W-1:0]          csr_data
);
   import gn2d_pkg::*;

   localparam int DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_GRID_SIDE);
   localparam int SW    = $clog2(MAX_GRID_SIDE + 1);

   logic [SIZE_W-1:0]         grid_width_ff, grid_height_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NOISE_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic [NOISE_W-1:0]        skid_data_ff, skid_data_in;

   logic                      advance, accept, take, res_valid, new_result;
   logic                      wr_en;
   logic signed [NOISE_W-1:0] res_value;
   pipe_ctrl_type             ctrl;
   logic [INDEX_W-1:0]        entry_index;
   logic [ENTRY_W-1:0]        entry_data;
   logic [POINT_W-1:0]        point_x, point_y;
   logic [3:0][AW-1:0]        corner_addr;
   logic [FRACTION_BITS-1:0]  frac_x, frac_y;
   logic [1:0][ENTRY_W-1:0]   grad_row0, grad_row1;

   // request fields
   assign entry_index = req_tdata[IDX_LSB +: INDEX_W];
   assign entry_data  = {req_tdata[GY_LSB +: GRAD_W], req_tdata[GX_LSB +: GRAD_W]};
   assign point_x     = req_tdata[PX_LSB +: POINT_W];
   assign point_y     = req_tdata[PY_LSB +: POINT_W];

   // pipeline moves whenever the skid slot is free
   assign advance      = !skid_valid_ff;
   assign req_tready   = advance;
   assign accept       = req_tvalid && advance;
   assign ctrl.advance = advance;
   assign ctrl.sample  = accept && (op_type'(req_tuser) == OP_SAMPLE);
   assign wr_en        = accept && (op_type'(req_tuser) == OP_WRITE) &&
                         (32'(entry_index) < 32'(DEPTH));

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= SIZE_RESET;
         grid_height_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // corner addresses and fractions
   gn2d_corner_addr #(
      .MAX_GRID_SIDE (MAX_GRID_SIDE),
      .FRACTION_BITS (FRACTION_BITS),
      .AW            (AW),
      .CW            (CW),
      .SW            (SW)
   ) u_corner_addr (
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .point_x     (point_x),
      .point_y     (point_y),
      .corner_addr (corner_addr),
      .frac_x      (frac_x),
      .frac_y      (frac_y)
   );

   // two table copies: lower row corners and upper row corners
   gn2d_gradient_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram_row0 (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(entry_index)),
      .wr_data (entry_data),
      .rd_en   (advance),
      .rd_addr ({corner_addr[1], corner_addr[0]}),
      .rd_data (grad_row0)
   );

   gn2d_gradient_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram_row1 (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(entry_index)),
      .wr_data (entry_data),
      .rd_en   (advance),
      .rd_addr ({corner_addr[3], corner_addr[2]}),
      .rd_data (grad_row1)
   );

   // dot products, fade and blends
   gn2d_interp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .frac_x    (frac_x),
      .frac_y    (frac_y),
      .grad_row0 (grad_row0),
      .grad_row1 (grad_row1),
      .res_valid (res_valid),
      .res_value (res_value)
   );

   // output register plus skid slot
   assign take       = rsp_valid_ff && rsp_tready;
   assign new_result = res_valid && advance;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (new_result) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = NOISE_W'(res_value);
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = NOISE_W'(res_value);
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/gn2d_gradient_ram.sv
module gn2d_gradient_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [AW-1:0]                         wr_addr,
   input  logic [gn2d_pkg::ENTRY_W-1:0]          wr_data,
   input  logic                                  rd_en,
   input  logic [1:0][AW-1:0]                    rd_addr,
   output logic [1:0][gn2d_pkg::ENTRY_W-1:0]     rd_data
);
   import gn2d_pkg::*;

   logic [ENTRY_W-1:0]      table_ff [DEPTH];
   logic [1:0][ENTRY_W-1:0] rd_data_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff[0] <= table_ff[rd_addr[0]];
         rd_data_ff[1] <= table_ff[rd_addr[1]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/gn2d_corner_addr.sv
module gn2d_corner_addr #(
   parameter int MAX_GRID_SIDE = 64,
   parameter int FRACTION_BITS = 8,
   parameter int AW            = 12,
   parameter int CW            = 6,
   parameter int SW            = 7
) (
   input  logic [gn2d_pkg::SIZE_W-1:0]   grid_width,
   input  logic [gn2d_pkg::SIZE_W-1:0]   grid_height,
   input  logic [gn2d_pkg::POINT_W-1:0]  point_x,
   input  logic [gn2d_pkg::POINT_W-1:0]  point_y,
   output logic [3:0][AW-1:0]            corner_addr,
   output logic [FRACTION_BITS-1:0]      frac_x,
   output logic [FRACTION_BITS-1:0]      frac_y
);
   import gn2d_pkg::*;

   localparam int PW = CW + SW;

   // zero acts as one, oversize clamps to the table side
   function automatic logic [SW-1:0] eff_size(input logic [SIZE_W-1:0] raw);
      logic [SW-1:0] size;
      if (raw == '0) begin
         size = SW'(1);
      end else if (32'(raw) > 32'(MAX_GRID_SIDE)) begin
         size = SW'(MAX_GRID_SIDE);
      end else begin
         size = SW'(raw);
      end
      return size;
   endfunction

   logic [SW-1:0] size_x, size_y;
   logic [31:0]   px_wide, py_wide, cell_x, cell_y, x0_inc, y0_inc;
   logic [CW-1:0] x0, x1, y0, y1;
   logic [PW-1:0] row0_base, row1_base;

   // split point into cell and fraction
   assign size_x  = eff_size(grid_width);
   assign size_y  = eff_size(grid_height);
   assign px_wide = 32'(point_x);
   assign py_wide = 32'(point_y);
   assign cell_x  = px_wide >> FRACTION_BITS;
   assign cell_y  = py_wide >> FRACTION_BITS;
   assign frac_x  = px_wide[FRACTION_BITS-1:0];
   assign frac_y  = py_wide[FRACTION_BITS-1:0];

   // corners at or past the edge wrap to zero
   assign x0     = (cell_x >= 32'(size_x)) ? '0 : CW'(cell_x);
   assign y0     = (cell_y >= 32'(size_y)) ? '0 : CW'(cell_y);
   assign x0_inc = 32'(x0) + 32'd1;
   assign y0_inc = 32'(y0) + 32'd1;
   assign x1     = (x0_inc >= 32'(size_x)) ? '0 : CW'(x0_inc);
   assign y1     = (y0_inc >= 32'(size_y)) ? '0 : CW'(y0_inc);

   // row times stride plus column
   assign row0_base      = PW'(y0) * PW'(size_x);
   assign row1_base      = PW'(y1) * PW'(size_x);
   assign corner_addr[0] = AW'(row0_base + PW'(x0));
   assign corner_addr[1] = AW'(row0_base + PW'(x1));
   assign corner_addr[2] = AW'(row1_base + PW'(x0));
   assign corner_addr[3] = AW'(row1_base + PW'(x1));

endmodule

// File: src/gn2d_interp.sv
module gn2d_interp #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gn2d_pkg::pipe_ctrl_type                ctrl,
   input  logic [FRACTION_BITS-1:0]               frac_x,
   input  logic [FRACTION_BITS-1:0]               frac_y,
   input  logic [1:0][gn2d_pkg::ENTRY_W-1:0]      grad_row0,
   input  logic [1:0][gn2d_pkg::ENTRY_W-1:0]      grad_row1,
   output logic                                   res_valid,
   output logic signed [gn2d_pkg::NOISE_W-1:0]    res_value
);
   import gn2d_pkg::*;

   localparam int F   = FRACTION_BITS;
   localparam int DW  = F + GRAD_W + 2;    // corner dot product
   localparam int BW  = DW + F + 3;        // x blend sum
   localparam int XW  = DW + 3;            // x blend after rounding
   localparam int YW  = XW + F + 3;        // y blend sum
   localparam int NW  = YW - 2 * F;        // noise before clamp

   localparam logic [F+1:0]          THREE_ONE = (F+2)'(3 << F);
   localparam logic [F:0]            ONE       = (F+1)'(1 << F);
   localparam logic [3*F+1:0]        FADE_RND  = (3*F+2)'(1) << (2*F - 1);
   localparam logic signed [BW-1:0]  X_RND     = BW'(1) <<< (F - 1);
   localparam logic signed [YW-1:0]  Y_RND     = YW'(1) <<< (2*F - 1);
   localparam logic signed [NW-1:0]  SAT_HI    = NW'((2 ** (NOISE_W - 1)) - 1);
   localparam logic signed [NW-1:0]  SAT_LO    = -NW'(2 ** (NOISE_W - 1));

   // stage 1: fractions alongside the registered table reads
   logic                 s1_valid_ff;
   logic [F-1:0]         s1_tx_ff, s1_ty_ff;

   // stage 2: dot products and fade partials
   logic                 s2_valid_ff;
   logic signed [DW-1:0] s2_dot_ff [4];
   logic signed [DW-1:0] s2_dot_in [4];
   logic [2*F-1:0]       s2_sq_ff [2];
   logic [2*F-1:0]       s2_sq_in [2];
   logic [F+1:0]         s2_cub_ff [2];
   logic [F+1:0]         s2_cub_in [2];

   // stage 3: faded fractions
   logic                 s3_valid_ff;
   logic signed [DW-1:0] s3_dot_ff [4];
   logic [F:0]           s3_fade_ff [2];
   logic [F:0]           s3_fade_in [2];

   // stage 4: x blends
   logic                 s4_valid_ff;
   logic signed [XW-1:0] s4_blend_ff [2];
   logic signed [XW-1:0] s4_blend_in [2];
   logic [F:0]           s4_fy_ff;

   logic signed [F:0]           dx0, dx1, dy0, dy1;
   logic signed [F:0]           dx [4];
   logic signed [F:0]           dy [4];
   logic [ENTRY_W-1:0]          entry [4];
   logic [3*F+1:0]              fade_prod [2];
   logic signed [F+1:0]         wx_lo, wx_hi, wy_lo, wy_hi;
   logic signed [BW-1:0]        xsum [2];
   logic signed [YW-1:0]        ysum;
   logic signed [NW-1:0]        noise_full;

   // corner offsets: t and t - one
   assign dx0 = $signed({1'b0, s1_tx_ff});
   assign dx1 = $signed({1'b1, s1_tx_ff});
   assign dy0 = $signed({1'b0, s1_ty_ff});
   assign dy1 = $signed({1'b1, s1_ty_ff});

   assign entry[0] = grad_row0[0];
   assign entry[1] = grad_row0[1];
   assign entry[2] = grad_row1[0];
   assign entry[3] = grad_row1[1];
   assign dx[0] = dx0;
   assign dx[1] = dx1;
   assign dx[2] = dx0;
   assign dx[3] = dx1;
   assign dy[0] = dy0;
   assign dy[1] = dy0;
   assign dy[2] = dy1;
   assign dy[3] = dy1;

   // four corner dot products, x in the low half of an entry
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s2_dot_in[i] = DW'(dx[i]) * DW'($signed(entry[i][GRAD_W-1:0])) +
                        DW'(dy[i]) * DW'($signed(entry[i][ENTRY_W-1:GRAD_W]));
      end
   end

   // fade partials: t squared and 3*one - 2t
   assign s2_sq_in[0]  = (2*F)'(s1_tx_ff) * (2*F)'(s1_tx_ff);
   assign s2_sq_in[1]  = (2*F)'(s1_ty_ff) * (2*F)'(s1_ty_ff);
   assign s2_cub_in[0] = THREE_ONE - {1'b0, s1_tx_ff, 1'b0};
   assign s2_cub_in[1] = THREE_ONE - {1'b0, s1_ty_ff, 1'b0};

   // fade with round half up
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         fade_prod[i]  = (3*F+2)'(s2_sq_ff[i]) * (3*F+2)'(s2_cub_ff[i]) + FADE_RND;
         s3_fade_in[i] = (F+1)'(fade_prod[i] >> (2*F));
      end
   end

   // x blend of each corner pair
   assign wx_lo = $signed({1'b0, ONE - s3_fade_ff[0]});
   assign wx_hi = $signed({1'b0, s3_fade_ff[0]});
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         xsum[i] = BW'(s3_dot_ff[2*i]) * BW'(wx_lo) +
                   BW'(s3_dot_ff[2*i+1]) * BW'(wx_hi) + X_RND;
         s4_blend_in[i] = XW'(xsum[i] >>> F);
      end
   end

   // y blend, scale to Q1.14 and clamp
   assign wy_lo      = $signed({1'b0, ONE - s4_fy_ff});
   assign wy_hi      = $signed({1'b0, s4_fy_ff});
   assign ysum       = YW'(s4_blend_ff[0]) * YW'(wy_lo) +
                       YW'(s4_blend_ff[1]) * YW'(wy_hi) + Y_RND;
   assign noise_full = NW'(ysum >>> (2*F));

   always_comb begin
      if (noise_full > SAT_HI) begin
         res_value = NOISE_W'(SAT_HI);
      end else if (noise_full < SAT_LO) begin
         res_value = NOISE_W'(SAT_LO);
      end else begin
         res_value = NOISE_W'(noise_full);
      end
   end

   assign res_valid = s4_valid_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         s1_valid_ff <= ctrl.sample;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         s1_tx_ff <= frac_x;
         s1_ty_ff <= frac_y;
         for (int i = 0; i < 4; i++) begin
            s2_dot_ff[i] <= s2_dot_in[i];
            s3_dot_ff[i] <= s2_dot_ff[i];
         end
         for (int i = 0; i < 2; i++) begin
            s2_sq_ff[i]    <= s2_sq_in[i];
            s2_cub_ff[i]   <= s2_cub_in[i];
            s3_fade_ff[i]  <= s3_fade_in[i];
            s4_blend_ff[i] <= s4_blend_in[i];
         end
         s4_fy_ff <= s3_fade_ff[1];
      end
   end

endmodule

// File: src/gn2d_checker.sv
module gn2d_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [gn2d_pkg::NOISE_W-1:0]         rsp_tdata
);

   // a stalled response keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reset empties the output side
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // requests are held back only with a response waiting in front
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side stalled with no response pending");

   // once the buffer is full it stays full until a response is taken
   assert property (@(posedge clock) disable iff (reset)
      !req_tready && !(rsp_tvalid && rsp_tready) |=> !req_tready)
      else $error("request side reopened without a response taken");

endmodule

bind gradient_noise_2d_sampler gn2d_checker u_gn2d_checker (.*);
